// ----- src/dpp_pkg.sv -----
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared widths, types and helpers for the direction-to-pixel projection.
// ----------------------------------------------------------------------------
package dpp_pkg;

    localparam int CB         = 21;               // bits per Q8.12 component
    localparam int VW         = 3 * CB;           // packed vector register
    localparam int DOTW       = 2 * CB + 3;       // any dot product, signed
    localparam int LOW        = (DOTW - 1) / 2;   // low slice of a split operand
    localparam int HIW        = DOTW - LOW;       // high slice, signed
    localparam int PPW        = 2 * HIW;          // partial product
    localparam int PRW        = 2 * DOTW;         // full product
    localparam int RW         = PRW - 1;          // ratio numerator/denominator
    localparam int AW         = RW + 2;           // divider accumulator
    localparam int PXW        = 13;               // pixel coordinate / size
    localparam int MAX_RES    = 4096;
    localparam int IDXW       = 3;
    localparam int QSW        = DOTW + 15;        // q scaled by threshold
    localparam int THRESH_DEN = 10000;
    localparam int THRESH_ONE = 1 << 24;

    typedef enum logic [IDXW-1:0] {
        REG_ORIGIN = 3'd0,
        REG_VIEW   = 3'd1,
        REG_CORNER = 3'd2,
        REG_XAXIS  = 3'd3,
        REG_YAXIS  = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6
    } reg_idx_t;

    typedef logic signed [CB-1:0]   comp_t;
    typedef logic signed [DOTW-1:0] dot_t;

    typedef struct packed {
        logic [VW-1:0]  nv;
        logic [VW-1:0]  xv;
        logic [VW-1:0]  yv;
        dot_t           n;
        dot_t           dxc;
        dot_t           dyc;
        dot_t           xx;
        dot_t           yy;
        logic           ok;
        logic [PXW-1:0] sw;
        logic [PXW-1:0] sh;
    } cfg_t;

    typedef struct packed {
        logic           hit;
        logic [RW-1:0]  rnx;
        logic [RW-1:0]  rdx;
        logic [RW-1:0]  rny;
        logic [RW-1:0]  rdy;
        logic [RW-1:0]  remx;
        logic [RW-1:0]  remy;
        logic [PXW-1:0] qx;
        logic [PXW-1:0] qy;
    } div_t;

    typedef struct packed {
        logic [RW-1:0]  rem;
        logic [PXW-1:0] q;
    } dstep_t;

    function automatic comp_t comp(input logic [VW-1:0] v, input int i);
        comp_t c;
        c = v[i*CB +: CB];
        return c;
    endfunction

    // One radix step of floor(size * rn / rd), size fed MSB first.
    // rem < rd on entry, so the digit is 0, 1 or 2.
    function automatic dstep_t dig_step(input logic [RW-1:0] rem,
                                        input logic [RW-1:0] rn,
                                        input logic [RW-1:0] rd,
                                        input logic sbit,
                                        input logic [PXW-1:0] q);
        logic [AW-1:0] t;
        logic [AW-1:0] t1;
        logic [AW-1:0] t2;
        dstep_t        r;
        t  = AW'({rem, 1'b0}) + (sbit ? AW'(rn) : '0);
        t1 = t - AW'(rd);
        t2 = t - AW'({rd, 1'b0});
        if (!t2[AW-1])
        begin
            r.rem = t2[RW-1:0];
            r.q   = PXW'({q, 1'b0}) + PXW'(2);
        end
        else if (!t1[AW-1])
        begin
            r.rem = t1[RW-1:0];
            r.q   = PXW'({q, 1'b0}) + PXW'(1);
        end
        else
        begin
            r.rem = t[RW-1:0];
            r.q   = PXW'({q, 1'b0});
        end
        return r;
    endfunction

endpackage

// ----- src/dpp_cfg.sv -----
// ----------------------------------------------------------------------------
// dpp_cfg
// Configuration registers and the camera terms that follow from them.
// ----------------------------------------------------------------------------
module dpp_cfg
    import dpp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [IDXW-1:0] cfg_idx,
    input  logic [VW-1:0]   cfg_data,
    output cfg_t            cfg
);

    logic [VW-1:0]  org_reg, view_reg, crn_reg, xax_reg, yax_reg;
    logic [PXW-1:0] w_reg, h_reg;
    dot_t           pn_reg [3];
    dot_t           px_reg [3];
    dot_t           py_reg [3];
    dot_t           pxx_reg [3];
    dot_t           pyy_reg [3];
    dot_t           n_reg, dxc_reg, dyc_reg, xx_reg, yy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg  <= '0;
            view_reg <= '0;
            crn_reg  <= '0;
            xax_reg  <= '0;
            yax_reg  <= '0;
            w_reg    <= PXW'(640);
            h_reg    <= PXW'(480);
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ORIGIN: org_reg  <= cfg_data;
                REG_VIEW:   view_reg <= cfg_data;
                REG_CORNER: crn_reg  <= cfg_data;
                REG_XAXIS:  xax_reg  <= cfg_data;
                REG_YAXIS:  yax_reg  <= cfg_data;
                REG_WIDTH:  w_reg    <= cfg_data[PXW-1:0];
                REG_HEIGHT: h_reg    <= cfg_data[PXW-1:0];
                default:    ;
            endcase
        end
    end

    // Products, then sums: two register levels behind the raw registers.
    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        logic signed [CB:0] so;
        logic signed [CB:0] dd;
        assign so = (CB+1)'(comp(crn_reg, i)) - (CB+1)'(comp(org_reg, i));
        assign dd = (CB+1)'(comp(org_reg, i)) - (CB+1)'(comp(crn_reg, i));
        always_ff @(posedge clk)
        begin
            pn_reg[i]  <= DOTW'(so) * DOTW'(comp(view_reg, i));
            px_reg[i]  <= DOTW'(dd) * DOTW'(comp(xax_reg, i));
            py_reg[i]  <= DOTW'(dd) * DOTW'(comp(yax_reg, i));
            pxx_reg[i] <= DOTW'(comp(xax_reg, i)) * DOTW'(comp(xax_reg, i));
            pyy_reg[i] <= DOTW'(comp(yax_reg, i)) * DOTW'(comp(yax_reg, i));
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= pn_reg[0] + pn_reg[1] + pn_reg[2];
        dxc_reg <= px_reg[0] + px_reg[1] + px_reg[2];
        dyc_reg <= py_reg[0] + py_reg[1] + py_reg[2];
        xx_reg  <= pxx_reg[0] + pxx_reg[1] + pxx_reg[2];
        yy_reg  <= pyy_reg[0] + pyy_reg[1] + pyy_reg[2];
    end

    assign cfg.nv  = view_reg;
    assign cfg.xv  = xax_reg;
    assign cfg.yv  = yax_reg;
    assign cfg.n   = n_reg;
    assign cfg.dxc = dxc_reg;
    assign cfg.dyc = dyc_reg;
    assign cfg.xx  = xx_reg;
    assign cfg.yy  = yy_reg;
    assign cfg.ok  = (n_reg > 0) && (xx_reg > 0) && (yy_reg > 0);
    assign cfg.sw  = (w_reg > PXW'(MAX_RES)) ? PXW'(MAX_RES) : w_reg;
    assign cfg.sh  = (h_reg > PXW'(MAX_RES)) ? PXW'(MAX_RES) : h_reg;

endmodule

// ----- src/dpp_front.sv -----
// ----------------------------------------------------------------------------
// dpp_front
// Six-stage front: dot products, split wide multiplies, ratio numerators and
// denominators with the range checks.
// ----------------------------------------------------------------------------
module dpp_front
    import dpp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  in_v,
    input  comp_t in_dx,
    input  comp_t in_dy,
    input  comp_t in_dz,
    output logic  up_rdy,
    output logic  out_v,
    output div_t  out_d,
    input  logic  dn_rdy
);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    comp_t d1_reg [3];
    logic signed [2*CB-1:0] pn2_reg [3];
    logic signed [2*CB-1:0] px2_reg [3];
    logic signed [2*CB-1:0] py2_reg [3];
    dot_t q3_reg, dx3_reg, dy3_reg;
    logic signed [PPW-1:0] pp4_reg [6][4];
    logic ok4_reg;
    logic signed [PRW-1:0] pr5_reg [6];
    logic ok5_reg;
    div_t d6_reg;

    dot_t mop_a [6];
    dot_t mop_b [6];
    logic signed [QSW-1:0] qs;

    assign en6    = !v6_reg || dn_rdy;
    assign en5    = !v5_reg || en6;
    assign en4    = !v4_reg || en5;
    assign en3    = !v3_reg || en4;
    assign en2    = !v2_reg || en3;
    assign en1    = !v1_reg || en2;
    assign up_rdy = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_v;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // stage 1: capture the direction
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1_reg[0] <= in_dx;
            d1_reg[1] <= in_dy;
            d1_reg[2] <= in_dz;
        end
    end

    // stage 2: component products against N, X and Y
    for (genvar i = 0; i < 3; i++)
    begin : g_s2
        always_ff @(posedge clk)
        begin
            if (en2)
            begin
                pn2_reg[i] <= (2*CB)'(d1_reg[i]) * (2*CB)'(comp(cfg.nv, i));
                px2_reg[i] <= (2*CB)'(d1_reg[i]) * (2*CB)'(comp(cfg.xv, i));
                py2_reg[i] <= (2*CB)'(d1_reg[i]) * (2*CB)'(comp(cfg.yv, i));
            end
        end
    end

    // stage 3: dot products
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            q3_reg  <= DOTW'(pn2_reg[0]) + DOTW'(pn2_reg[1]) + DOTW'(pn2_reg[2]);
            dx3_reg <= DOTW'(px2_reg[0]) + DOTW'(px2_reg[1]) + DOTW'(px2_reg[2]);
            dy3_reg <= DOTW'(py2_reg[0]) + DOTW'(py2_reg[1]) + DOTW'(py2_reg[2]);
        end
    end

    // stage 4: partial products of the six wide multiplies
    assign mop_a[0] = q3_reg;  assign mop_b[0] = cfg.dxc;
    assign mop_a[1] = dx3_reg; assign mop_b[1] = cfg.n;
    assign mop_a[2] = q3_reg;  assign mop_b[2] = cfg.xx;
    assign mop_a[3] = q3_reg;  assign mop_b[3] = cfg.dyc;
    assign mop_a[4] = dy3_reg; assign mop_b[4] = cfg.n;
    assign mop_a[5] = q3_reg;  assign mop_b[5] = cfg.yy;

    for (genvar m = 0; m < 6; m++)
    begin : g_s4
        logic signed [HIW-1:0] ah, al, bh, bl;
        assign ah = mop_a[m][DOTW-1:LOW];
        assign al = $signed({1'b0, mop_a[m][LOW-1:0]});
        assign bh = mop_b[m][DOTW-1:LOW];
        assign bl = $signed({1'b0, mop_b[m][LOW-1:0]});
        always_ff @(posedge clk)
        begin
            if (en4)
            begin
                pp4_reg[m][0] <= PPW'(ah) * PPW'(bh);
                pp4_reg[m][1] <= PPW'(ah) * PPW'(bl);
                pp4_reg[m][2] <= PPW'(al) * PPW'(bh);
                pp4_reg[m][3] <= PPW'(al) * PPW'(bl);
            end
        end
    end

    // q must reach 0.0001: q * 10000 >= 1.0 in Q.24
    assign qs = QSW'(q3_reg) * QSW'($signed(15'(THRESH_DEN)));

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            ok4_reg <= (qs >= $signed(QSW'(THRESH_ONE))) && cfg.ok;
        end
    end

    // stage 5: recombine the partial products
    for (genvar m = 0; m < 6; m++)
    begin : g_s5
        always_ff @(posedge clk)
        begin
            if (en5)
            begin
                pr5_reg[m] <= (PRW'(pp4_reg[m][0]) <<< (2*LOW))
                            + ((PRW'(pp4_reg[m][1]) + PRW'(pp4_reg[m][2])) <<< LOW)
                            + PRW'(pp4_reg[m][3]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            ok5_reg <= ok4_reg;
        end
    end

    // stage 6: numerators, range check of both ratios
    logic signed [PRW:0] rnx, rdx, rny, rdy;
    assign rnx = (PRW+1)'(pr5_reg[0]) + (PRW+1)'(pr5_reg[1]);
    assign rdx = (PRW+1)'(pr5_reg[2]);
    assign rny = (PRW+1)'(pr5_reg[3]) + (PRW+1)'(pr5_reg[4]);
    assign rdy = (PRW+1)'(pr5_reg[5]);

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            d6_reg.hit  <= ok5_reg && !rnx[PRW] && (rnx <= rdx)
                                   && !rny[PRW] && (rny <= rdy);
            d6_reg.rnx  <= rnx[RW-1:0];
            d6_reg.rdx  <= rdx[RW-1:0];
            d6_reg.rny  <= rny[RW-1:0];
            d6_reg.rdy  <= rdy[RW-1:0];
            d6_reg.remx <= '0;
            d6_reg.remy <= '0;
            d6_reg.qx   <= '0;
            d6_reg.qy   <= '0;
        end
    end

    assign out_v = v6_reg;
    assign out_d = d6_reg;

endmodule

// ----- src/dpp_div_stage.sv -----
// ----------------------------------------------------------------------------
// dpp_div_stage
// One pipelined digit step of floor(size * rn / rd) for both screen axes.
// ----------------------------------------------------------------------------
module dpp_div_stage
    import dpp_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [PXW-1:0] sw,
    input  logic [PXW-1:0] sh,
    input  logic           in_v,
    input  div_t           in_d,
    output logic           up_rdy,
    output logic           out_v,
    output div_t           out_d,
    input  logic           dn_rdy
);

    logic   v_reg;
    div_t   d_reg;
    div_t   d_next;
    logic   en;
    dstep_t sx, sy;

    assign en     = !v_reg || dn_rdy;
    assign up_rdy = en;

    assign sx = dig_step(in_d.remx, in_d.rnx, in_d.rdx, sw[PXW-1-STEP], in_d.qx);
    assign sy = dig_step(in_d.remy, in_d.rny, in_d.rdy, sh[PXW-1-STEP], in_d.qy);

    always_comb
    begin
        d_next      = in_d;
        d_next.remx = sx.rem;
        d_next.qx   = sx.q;
        d_next.remy = sy.rem;
        d_next.qy   = sy.q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign out_v = v_reg;
    assign out_d = d_reg;

endmodule

// ----- src/direction_to_pixel_projection.sv -----
// ----------------------------------------------------------------------------
// direction_to_pixel_projection
// Projects a ray direction onto the pinhole camera's view screen.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry dir_x, dir_y, dir_z (signed Q8.12).
// A transfer happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid/out_stall carry hit, pixel_x, pixel_y; pixel
// coordinates read zero on a miss.
// Configuration: cfg_we writes cfg_data into register cfg_idx (origin, view
// axis, screen corner, screen x and y axes, width, height). Write only while
// no ray is in flight.
// Throughput: one ray per cycle while out_stall is low. A ray passes from
// input transfer to out_valid through six front stages (dot products, split
// 45x45 multiplies, ratio check), one divider stage per pixel-coordinate bit
// and the output register.
// Reset clears all stage valids and loads the register defaults (vectors
// zero, 640x480). When the receiver stalls, the result holds and the
// pipeline closes its bubbles before in_stall rises.
// ----------------------------------------------------------------------------
module direction_to_pixel_projection
    import dpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [IDXW-1:0]       cfg_idx,
    input  logic [VW-1:0]         cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [CB-1:0]  dir_x,
    input  logic signed [CB-1:0]  dir_y,
    input  logic signed [CB-1:0]  dir_z,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [PXW-1:0]        pixel_x,
    output logic [PXW-1:0]        pixel_y
);

    cfg_t cfg;
    logic front_rdy;
    logic dv   [PXW+1];
    div_t dd   [PXW+1];
    logic drdy [PXW+1];

    logic           out_valid_reg;
    logic           hit_reg;
    logic [PXW-1:0] px_reg, py_reg;

    dpp_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    dpp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_v   (in_valid),
        .in_dx  (dir_x),
        .in_dy  (dir_y),
        .in_dz  (dir_z),
        .up_rdy (front_rdy),
        .out_v  (dv[0]),
        .out_d  (dd[0]),
        .dn_rdy (drdy[0])
    );

    for (genvar k = 0; k < PXW; k++)
    begin : g_div
        dpp_div_stage #(.STEP(k)) u_stage (
            .clk    (clk),
            .rst_n  (rst_n),
            .sw     (cfg.sw),
            .sh     (cfg.sh),
            .in_v   (dv[k]),
            .in_d   (dd[k]),
            .up_rdy (drdy[k]),
            .out_v  (dv[k+1]),
            .out_d  (dd[k+1]),
            .dn_rdy (drdy[k+1])
        );
    end

    assign drdy[PXW] = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (drdy[PXW])
        begin
            out_valid_reg <= dv[PXW];
        end
    end

    // zero the coordinates of a miss
    always_ff @(posedge clk)
    begin
        if (drdy[PXW])
        begin
            hit_reg <= dd[PXW].hit;
            px_reg  <= dd[PXW].hit ? dd[PXW].qx : '0;
            py_reg  <= dd[PXW].hit ? dd[PXW].qy : '0;
        end
    end

    assign in_stall  = !front_rdy;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> pixel_x == '0 && pixel_y == '0)
        else $error("miss with nonzero pixel");

    a_pixel_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> pixel_x <= cfg.sw && pixel_y <= cfg.sh)
        else $error("pixel beyond image size");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg && out_stall && dv[PXW])
        else $error("input stalled with room in the pipeline");

endmodule
